// ===== rtl/reference_count_table_assert.svh =====
// Assertion macros used by the top level of the reference count table RTL.
`ifndef REFERENCE_COUNT_TABLE_ASSERT_SVH
`define REFERENCE_COUNT_TABLE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication under reset.
`define RCT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rct assertion failed");
// Next-cycle implication under reset.
`define RCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rct assertion failed");
`else
`define RCT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/rct_pkg.sv =====
// Shared types and constants of the reference count table.
package rct_pkg;

    localparam int DEF_NUM_SETS = 256;
    localparam int DEF_NUM_WAYS = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [63:0] MIX_K1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_K2 = 64'hc4ceb9fe1a85ec53;
    localparam int MIX_SHIFT = 33;

    // hash bits taken per cycle of the set reduction (one remainder digit)
    localparam int MOD_DIGIT = 4;
    localparam int MOD_STEPS = 64 / MOD_DIGIT;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_QUERY  = 3'd0;
    localparam t_kind KIND_INC    = 3'd1;
    localparam t_kind KIND_DEC    = 3'd2;
    localparam t_kind KIND_REMOVE = 3'd3;
    localparam t_kind KIND_TAKE   = 3'd4;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic               valid;
        logic               in_zero;
        logic [63:0]        key;
        logic signed [31:0] count;
    } t_entry;

    typedef struct packed {
        logic clearing;
    } t_bstat;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_MOD,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_SET,
        B_LNK,
        B_PUSH1,
        B_PUSH2,
        B_DONE
    } t_bstate;

endpackage

// ===== rtl/reference_count_table.sv =====
// Top level of the set-associative reference count table.
//
//  channel   valid    stall    payload
//  input     i_valid  o_stall  i_kind, i_key
//  output    o_valid  i_stall  o_status, o_count, o_key_out
//
// The front end takes one transfer at a time, none new until the last is
// queued: an accept, the shared 32x32 multiplier for the two hash products,
// 4-bit remainder steps for the set index and a queue write, in that order.
// The back end steps through a set row read, write and link read/writes per
// operation and is quicker, so the front hash unit sets the sustained rate.
// After reset a clearing pass over all NUM_SETS sets empties the set table;
// items are taken into the front and queue meanwhile but executed after it.
// A stalled output holds the back end; a full queue holds the front end.
`include "reference_count_table_assert.svh"

module reference_count_table
    import rct_pkg::*;
#(
    parameter int NUM_SETS = DEF_NUM_SETS,
    parameter int NUM_WAYS = DEF_NUM_WAYS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_kind,
    input  logic [63:0]        i_key,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_count,
    output logic [63:0]        o_key_out
);

    localparam int SB = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int QW = 3 + 64 + SB;

    logic          q_push, q_pop, q_full, q_empty;
    logic [2:0]    f_kind;
    logic [63:0]   f_key;
    logic [SB-1:0] f_set;
    logic [QW-1:0] q_out;
    t_bstat        bstat;

    rct_front #(
        .NUM_SETS (NUM_SETS),
        .SB       (SB)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_kind   (i_kind),
        .i_key    (i_key),
        .o_q_push (q_push),
        .i_q_full (q_full),
        .o_kind   (f_kind),
        .o_key    (f_key),
        .o_set    (f_set)
    );

    rct_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_kind, f_key, f_set}),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rct_back #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS),
        .SB       (SB)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_kind    (q_out[QW-1:QW-3]),
        .i_key     (q_out[SB+63:SB]),
        .i_set     (q_out[SB-1:0]),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_status  (o_status),
        .o_count   (o_count),
        .o_key_out (o_key_out),
        .o_stat    (bstat)
    );

    `RCT_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, q_push, !q_full)
    `RCT_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, q_pop, !q_empty)
    `RCT_ASSERT_IMP(a_no_pop_clear, i_clk, i_rst_n, bstat.clearing, !q_pop)
    `RCT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

endmodule

// ===== rtl/rct_front.sv =====
// Front end: accepts operations, hashes the key to a set, queues the result.
module rct_front
    import rct_pkg::*;
#(
    parameter int NUM_SETS = DEF_NUM_SETS,
    parameter int SB = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [2:0]    i_kind,
    input  logic [63:0]   i_key,
    output logic          o_q_push,
    input  logic          i_q_full,
    output logic [2:0]    o_kind,
    output logic [63:0]   o_key,
    output logic [SB-1:0] o_set
);

    localparam int RB = SB + 1;
    localparam int CB = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    t_fstate       r_state, n_state;
    logic [1:0]    r_step, n_step;
    logic          r_pass, n_pass;
    logic [CB-1:0] r_cnt, n_cnt;
    logic [2:0]    r_kind, n_kind;
    logic [63:0]   r_key, n_key;
    logic [63:0]   r_x, n_x;
    logic [63:0]   r_acc, n_acc;
    logic [63:0]   r_prod, n_prod;
    logic [63:0]   r_src, n_src;
    logic [RB-1:0] r_rem, n_rem;

    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_p;

    // pick the partial product of this step
    always_comb begin
        logic [63:0] c;
        c = r_pass ? MIX_K2 : MIX_K1;
        unique case (r_step)
            2'd1: begin
                mul_a = r_x[31:0];
                mul_b = c[63:32];
            end
            2'd2: begin
                mul_a = r_x[63:32];
                mul_b = c[31:0];
            end
            default: begin
                mul_a = r_x[31:0];
                mul_b = c[31:0];
            end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    // next state and datapath
    always_comb begin
        logic [63:0]   fin;
        logic [63:0]   mixed;
        logic [RB-1:0] rem;
        n_state  = r_state;
        n_step   = r_step;
        n_pass   = r_pass;
        n_cnt    = r_cnt;
        n_kind   = r_kind;
        n_key    = r_key;
        n_x      = r_x;
        n_acc    = r_acc;
        n_prod   = r_prod;
        n_src    = r_src;
        n_rem    = r_rem;
        o_q_push = 1'b0;
        fin      = {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
        mixed    = fin ^ (fin >> MIX_SHIFT);
        rem      = r_rem;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_kind  = i_kind;
                    n_key   = i_key;
                    n_x     = i_key ^ (i_key >> MIX_SHIFT);
                    n_step  = 2'd0;
                    n_pass  = 1'b0;
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_prod = mul_p;
                n_step = r_step + 2'd1;
                unique case (r_step)
                    2'd0: ;
                    2'd1: n_acc = r_prod;
                    2'd2: n_acc = fin;
                    2'd3: begin
                        n_x = mixed;
                        if (!r_pass) begin
                            n_pass = 1'b1;
                        end else begin
                            n_src   = mixed;
                            n_rem   = '0;
                            n_cnt   = '0;
                            n_state = F_MOD;
                        end
                    end
                endcase
            end
            F_MOD: begin
                // shift in digits of the hash, reduce below the set count
                for (int b = 0; b < MOD_DIGIT; b++) begin
                    rem = {rem[RB-2:0], r_src[63-b]};
                    if (rem >= RB'(NUM_SETS)) begin
                        rem = rem - RB'(NUM_SETS);
                    end
                end
                n_rem = rem;
                n_src = r_src << MOD_DIGIT;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CB'(MOD_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = F_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
            r_pass  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pass  <= n_pass;
            r_cnt   <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_key  <= n_key;
        r_x    <= n_x;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_src  <= n_src;
        r_rem  <= n_rem;
    end

    assign o_stall = (r_state != F_IDLE);
    assign o_kind  = r_kind;
    assign o_key   = r_key;
    assign o_set   = r_rem[SB-1:0];

endmodule

// ===== rtl/rct_queue.sv =====
// Short queue between the front and back ends.
module rct_queue
    import rct_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NB = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PB-1:0]    r_wp, n_wp;
    logic [PB-1:0]    r_rp, n_rp;
    logic [NB-1:0]    r_cnt, n_cnt;

    // advance pointers and fill count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PB'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PB'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == NB'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

// ===== rtl/rct_back.sv =====
// Back end: set table, zero list links and the operation sequencer.
module rct_back
    import rct_pkg::*;
#(
    parameter int NUM_SETS = DEF_NUM_SETS,
    parameter int NUM_WAYS = DEF_NUM_WAYS,
    parameter int SB = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic [2:0]         i_kind,
    input  logic [63:0]        i_key,
    input  logic [SB-1:0]      i_set,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_count,
    output logic [63:0]        o_key_out,
    output t_bstat             o_stat
);

    localparam int WB = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int LB = SB + WB;
    localparam int LDEPTH = 1 << LB;
    localparam logic [LB:0] NULL_LNK = {1'b1, {LB{1'b0}}};

    t_entry [NUM_WAYS-1:0] r_set_mem [NUM_SETS];
    logic [LB:0]           r_prev_mem [LDEPTH];
    logic [LB:0]           r_next_mem [LDEPTH];

    t_entry [NUM_WAYS-1:0] r_set_q;
    logic [LB:0]           r_prev_q, r_next_q;

    logic [SB-1:0]         s_raddr, s_waddr;
    logic                  s_we;
    t_entry [NUM_WAYS-1:0] s_wdata;
    logic [LB-1:0]         l_raddr;
    logic                  p_we, x_we;
    logic [LB-1:0]         p_waddr, x_waddr;
    logic [LB:0]           p_wdata, x_wdata;

    t_bstate            r_state, n_state;
    logic [SB-1:0]      r_clr, n_clr;
    logic [LB:0]        r_head, n_head;
    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_kind, n_kind;
    logic [63:0]        r_key, n_key;
    logic [SB-1:0]      r_set, n_set;
    logic [WB-1:0]      r_way, n_way;
    logic [1:0]         r_status, n_status;
    logic signed [31:0] r_count, n_count;
    logic [63:0]        r_kout, n_kout;
    logic [1:0]         r_out_status, n_out_status;
    logic signed [31:0] r_out_count, n_out_count;
    logic [63:0]        r_out_kout, n_out_kout;

    // sequencer
    always_comb begin
        t_entry [NUM_WAYS-1:0] row;
        t_entry                cur;
        logic                  hit, free;
        logic [WB-1:0]         hit_way, free_way, e;
        logic signed [31:0]    newc;
        logic                  unl, psh;
        logic [LB-1:0]         idx;
        n_state      = r_state;
        n_clr        = r_clr;
        n_head       = r_head;
        n_out_valid  = r_out_valid && i_stall;
        n_kind       = r_kind;
        n_key        = r_key;
        n_set        = r_set;
        n_way        = r_way;
        n_status     = r_status;
        n_count      = r_count;
        n_kout       = r_kout;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_kout   = r_out_kout;
        o_q_pop      = 1'b0;
        s_raddr      = r_set;
        s_we         = 1'b0;
        s_waddr      = r_set;
        s_wdata      = r_set_q;
        l_raddr      = {r_set, r_way};
        p_we         = 1'b0;
        p_waddr      = {r_set, r_way};
        p_wdata      = NULL_LNK;
        x_we         = 1'b0;
        x_waddr      = {r_set, r_way};
        x_wdata      = r_head;
        row          = r_set_q;
        hit          = 1'b0;
        free         = 1'b0;
        hit_way      = '0;
        free_way     = '0;
        unl          = 1'b0;
        psh          = 1'b0;
        idx          = {r_set, r_way};
        // lowest matching way and lowest free way
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (row[w].valid && row[w].key == r_key) begin
                hit     = 1'b1;
                hit_way = WB'(w);
            end
            if (!row[w].valid) begin
                free     = 1'b1;
                free_way = WB'(w);
            end
        end
        e    = (r_kind == KIND_TAKE) ? r_way : hit_way;
        cur  = row[e];
        newc = cur.count;
        unique case (r_state)
            B_CLEAR: begin
                s_we    = 1'b1;
                s_waddr = r_clr;
                s_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == SB'(NUM_SETS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_kind  = i_kind;
                    n_key   = i_key;
                    if (i_kind == KIND_TAKE) begin
                        s_raddr = r_head[LB-1:WB];
                        n_set   = r_head[LB-1:WB];
                        n_way   = r_head[WB-1:0];
                    end else begin
                        s_raddr = i_set;
                        n_set   = i_set;
                    end
                    n_state = B_SET;
                end
            end
            B_SET: begin
                n_status = ST_OK;
                n_count  = '0;
                n_kout   = '0;
                n_way    = e;
                unique case (r_kind)
                    KIND_QUERY: begin
                        if (hit) n_count = cur.count;
                        else n_status = ST_NOT_FOUND;
                    end
                    KIND_INC: begin
                        if (hit) begin
                            unl = (cur.count == 32'sd0) && cur.in_zero;
                            if (cur.count != 32'sh7fffffff) newc = cur.count + 32'sd1;
                            row[e].count   = newc;
                            row[e].in_zero = cur.in_zero && !unl;
                            s_we    = 1'b1;
                            n_count = newc;
                        end else if (free) begin
                            row[free_way] = '{valid: 1'b1, in_zero: 1'b0,
                                              key: r_key, count: 32'sd1};
                            s_we    = 1'b1;
                            n_count = 32'sd1;
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                    KIND_DEC: begin
                        if (hit) begin
                            if (cur.count != 32'sh80000000) newc = cur.count - 32'sd1;
                            psh = (newc == 32'sd0) && !cur.in_zero;
                            row[e].count   = newc;
                            row[e].in_zero = cur.in_zero || psh;
                            s_we    = 1'b1;
                            n_count = newc;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    KIND_REMOVE: begin
                        if (hit) begin
                            unl            = cur.in_zero;
                            row[e].valid   = 1'b0;
                            row[e].in_zero = 1'b0;
                            s_we           = 1'b1;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    KIND_TAKE: begin
                        if (r_head[LB]) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_kout         = cur.key;
                            unl            = 1'b1;
                            row[e].valid   = 1'b0;
                            row[e].in_zero = 1'b0;
                            s_we           = 1'b1;
                        end
                    end
                    default: ;
                endcase
                s_wdata = row;
                l_raddr = {r_set, e};
                if (unl) n_state = B_LNK;
                else if (psh) n_state = B_PUSH1;
                else n_state = B_DONE;
            end
            B_LNK: begin
                // splice the entry out of the zero list
                if (!r_prev_q[LB]) begin
                    x_we    = 1'b1;
                    x_waddr = r_prev_q[LB-1:0];
                    x_wdata = r_next_q;
                end else begin
                    n_head = r_next_q;
                end
                if (!r_next_q[LB]) begin
                    p_we    = 1'b1;
                    p_waddr = r_next_q[LB-1:0];
                    p_wdata = r_prev_q;
                end
                n_state = B_DONE;
            end
            B_PUSH1: begin
                p_we    = 1'b1;
                p_wdata = NULL_LNK;
                x_we    = 1'b1;
                x_wdata = r_head;
                n_state = B_PUSH2;
            end
            B_PUSH2: begin
                if (!r_head[LB]) begin
                    p_we    = 1'b1;
                    p_waddr = r_head[LB-1:0];
                    p_wdata = {1'b0, idx};
                end
                n_head  = {1'b0, idx};
                n_state = B_DONE;
            end
            B_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = r_count;
                    n_out_kout   = r_kout;
                    n_state      = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_head      <= NULL_LNK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_set        <= n_set;
        r_way        <= n_way;
        r_status     <= n_status;
        r_count      <= n_count;
        r_kout       <= n_kout;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_kout   <= n_out_kout;
    end

    // set table memory
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_set_mem[s_waddr] <= s_wdata;
        end
        r_set_q <= r_set_mem[s_raddr];
    end

    // zero list link memories
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_prev_mem[p_waddr] <= p_wdata;
        end
        r_prev_q <= r_prev_mem[l_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (x_we) begin
            r_next_mem[x_waddr] <= x_wdata;
        end
        r_next_q <= r_next_mem[l_raddr];
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_count         = r_out_count;
    assign o_key_out       = r_out_kout;
    assign o_stat.clearing = (r_state == B_CLEAR);

endmodule

// ===== test/reference_count_table_tb.sv =====
// Self-checking testbench for the set-associative reference count table.
`timescale 1ns / 1ps

module reference_count_table_tb;
    import rct_pkg::*;

    localparam int NSETS     = DEF_NUM_SETS;
    localparam int NWAYS     = DEF_NUM_WAYS;
    localparam int NENT      = NSETS * NWAYS;
    localparam int NIL       = NENT;
    localparam int N_RANDOM  = 830;
    localparam int POOL_SIZE = 48;

    typedef struct {
        t_kind              kind;
        logic [63:0]        key;
        bit                 typed;
        t_status            status;
        logic signed [31:0] count;
        logic [63:0]        key_out;
    } t_op;

    typedef struct {
        t_status            status;
        logic signed [31:0] count;
        logic [63:0]        key_out;
    } t_res;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_kind;
    logic [63:0]        i_key;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_status;
    logic signed [31:0] o_count;
    logic [63:0]        o_key_out;

    reference_count_table u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_kind    (i_kind),
        .i_key     (i_key),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_status  (o_status),
        .o_count   (o_count),
        .o_key_out (o_key_out)
    );

    // Shadow copy of the table and zero list
    bit                 tbl_valid [NENT];
    logic [63:0]        tbl_key   [NENT];
    logic signed [31:0] tbl_count [NENT];
    bit                 tbl_inzero[NENT];
    int                 zl_prev   [NENT];
    int                 zl_next   [NENT];
    int                 zl_head;

    t_op   ops[$];
    t_res  pending_results[$];
    t_op   drv_op;
    int    accepted_items;
    int    mismatches;
    bit    hold_long;

    function automatic int set_index(logic [63:0] k);
        logic [63:0] h;
        h = k;
        h = h ^ (h >> MIX_SHIFT);
        h = h * MIX_K1;
        h = h ^ (h >> MIX_SHIFT);
        h = h * MIX_K2;
        h = h ^ (h >> MIX_SHIFT);
        return int'(h % NSETS);
    endfunction

    function automatic int find_entry(logic [63:0] k);
        int b;
        b = set_index(k) * NWAYS;
        for (int w = 0; w < NWAYS; w++)
            if (tbl_valid[b + w] && tbl_key[b + w] == k) return b + w;
        return NIL;
    endfunction

    function automatic void zl_push(int i);
        zl_prev[i] = NIL;
        zl_next[i] = zl_head;
        if (zl_head != NIL) zl_prev[zl_head] = i;
        zl_head = i;
        tbl_inzero[i] = 1'b1;
    endfunction

    function automatic void zl_unlink(int i);
        int p;
        int n;
        p = zl_prev[i];
        n = zl_next[i];
        if (p != NIL) zl_next[p] = n;
        else zl_head = n;
        if (n != NIL) zl_prev[n] = p;
        tbl_inzero[i] = 1'b0;
    endfunction

    // Apply one operation to the shadow table and return its result
    function automatic t_res table_update(t_kind kind, logic [63:0] k);
        t_res r;
        int   i;
        int   b;
        r = '{ST_OK, 32'sd0, 64'd0};
        case (kind)
            KIND_QUERY: begin
                i = find_entry(k);
                if (i != NIL) r.count = tbl_count[i];
                else r.status = ST_NOT_FOUND;
            end
            KIND_INC: begin
                i = find_entry(k);
                if (i != NIL) begin
                    if (tbl_count[i] == 0 && tbl_inzero[i]) zl_unlink(i);
                    if (tbl_count[i] != 32'sh7fffffff) tbl_count[i]++;
                    r.count = tbl_count[i];
                end else begin
                    b = set_index(k) * NWAYS;
                    r.status = ST_FULL;
                    for (int w = 0; w < NWAYS; w++) begin
                        if (!tbl_valid[b + w]) begin
                            tbl_valid[b + w]  = 1'b1;
                            tbl_key[b + w]    = k;
                            tbl_count[b + w]  = 1;
                            tbl_inzero[b + w] = 1'b0;
                            r.status = ST_OK;
                            r.count  = 1;
                            break;
                        end
                    end
                end
            end
            KIND_DEC: begin
                i = find_entry(k);
                if (i != NIL) begin
                    if (tbl_count[i] != 32'sh80000000) tbl_count[i]--;
                    if (tbl_count[i] == 0 && !tbl_inzero[i]) zl_push(i);
                    r.count = tbl_count[i];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            KIND_REMOVE: begin
                i = find_entry(k);
                if (i != NIL) begin
                    if (tbl_inzero[i]) zl_unlink(i);
                    tbl_valid[i] = 1'b0;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            KIND_TAKE: begin
                i = zl_head;
                if (i != NIL) begin
                    r.key_out = tbl_key[i];
                    zl_unlink(i);
                    tbl_valid[i] = 1'b0;
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void add_op(t_kind kind, logic [63:0] k, bit typed = 0,
                                   t_status st = ST_OK, logic signed [31:0] cnt = 0,
                                   logic [63:0] ko = 0);
        t_op o;
        o = '{kind, k, typed, st, cnt, ko};
        ops.push_back(o);
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predict on each input transfer, check on each output transfer
    always @(posedge i_clk) begin
        t_res exp_r;
        t_res got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                exp_r = table_update(drv_op.kind, drv_op.key);
                if (drv_op.typed) exp_r = '{drv_op.status, drv_op.count, drv_op.key_out};
                pending_results.push_back(exp_r);
                accepted_items++;
            end
            if (o_valid && !i_stall) begin
                got = '{o_status, o_count, o_key_out};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d count %0d key_out %h",
                                 got.status, got.count, got.key_out);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got.status !== exp_r.status || got.count !== exp_r.count ||
                        got.key_out !== exp_r.key_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: status %0d/%0d count %0d/%0d key_out %h/%h",
                                     exp_r.status, got.status, exp_r.count, got.count,
                                     exp_r.key_out, got.key_out);
                    end
                end
            end
        end
    end

    // Receiver: random stall pattern, plus one long hold-off
    initial begin
        int mode;
        int run;
        bit long_done;
        i_stall = 1'b0;
        long_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_long && !long_done) begin
                long_done = 1'b1;
                i_stall = 1'b1;
                repeat (600) @(negedge i_clk);
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(1, 60);
            repeat (run) begin
                case (mode)
                    0: i_stall = 1'b0;
                    1: i_stall = ($urandom_range(0, 3) == 0);
                    2: i_stall = ($urandom_range(0, 1) == 1);
                    default: i_stall = ($urandom_range(0, 3) != 0);
                endcase
                @(negedge i_clk);
            end
        end
    end

    // Sender and run control
    initial begin
        logic [63:0] pool[$];
        logic [63:0] cset[$];
        logic [63:0] k;
        logic [63:0] ka;
        logic [63:0] kb;
        int          burst;
        int          target;
        int          sel;
        int          waited;
        t_kind       kd;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind  = KIND_QUERY;
        i_key   = '0;
        accepted_items = 0;
        mismatches = 0;
        hold_long = 1'b0;
        drv_op = '{KIND_QUERY, 64'd0, 1'b0, ST_OK, 0, 64'd0};
        for (int i = 0; i < NENT; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_inzero[i] = 1'b0;
        end
        zl_head = NIL;

        // Five keys in one set, to fill it and overflow
        k = {$urandom, $urandom};
        cset.push_back(k);
        target = set_index(k);
        while (cset.size() < NWAYS + 1) begin
            k = {$urandom, $urandom};
            if (set_index(k) == target) cset.push_back(k);
        end

        ka = 64'd0;
        kb = '1;
        // Directed table: empty table, key extremes, zero list, full set, unused kinds
        add_op(KIND_QUERY,  ka, 1, ST_NOT_FOUND);
        add_op(KIND_TAKE,   ka, 1, ST_EMPTY);
        add_op(KIND_DEC,    ka, 1, ST_NOT_FOUND);
        add_op(KIND_REMOVE, ka, 1, ST_NOT_FOUND);
        add_op(KIND_INC,    ka, 1, ST_OK, 1);
        add_op(KIND_INC,    kb, 1, ST_OK, 1);
        add_op(KIND_INC,    ka);
        add_op(KIND_DEC,    ka);
        add_op(KIND_DEC,    ka);
        add_op(KIND_DEC,    ka);
        add_op(KIND_QUERY,  ka);
        add_op(KIND_DEC,    kb);
        add_op(KIND_TAKE,   ka);
        add_op(KIND_TAKE,   ka);
        add_op(KIND_TAKE,   kb, 1, ST_EMPTY);
        for (int i = 0; i < NWAYS; i++) add_op(KIND_INC, cset[i], 1, ST_OK, 1);
        add_op(KIND_INC,    cset[NWAYS], 1, ST_FULL);
        add_op(KIND_DEC,    cset[0]);
        add_op(KIND_INC,    cset[0]);
        add_op(KIND_DEC,    cset[1]);
        add_op(KIND_REMOVE, cset[1]);
        add_op(KIND_TAKE,   ka, 1, ST_EMPTY);
        add_op(3'd5, kb, 1);
        add_op(3'd6, ka, 1);
        add_op(3'd7, kb, 1);

        // Random part: mostly a small key pool so entries get hit often
        for (int i = 0; i < POOL_SIZE; i++) pool.push_back({$urandom, $urandom});
        foreach (cset[i]) pool.push_back(cset[i]);
        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 99);
            k = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                             : pool[$urandom_range(0, pool.size() - 1)];
            if (sel < 33) kd = KIND_INC;
            else if (sel < 63) kd = KIND_DEC;
            else if (sel < 77) kd = KIND_QUERY;
            else if (sel < 86) kd = KIND_REMOVE;
            else if (sel < 96) kd = KIND_TAKE;
            else kd = t_kind'($urandom_range(5, 7));
            add_op(kd, k);
        end

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drive items in bursts separated by idle gaps
        burst = 0;
        foreach (ops[n]) begin
            if (burst == 0) begin
                i_valid = 1'b0;
                repeat ($urandom_range(0, 40)) @(negedge i_clk);
                burst = $urandom_range(1, 20);
            end
            drv_op = ops[n];
            i_kind = ops[n].kind;
            i_key  = ops[n].key;
            i_valid = 1'b1;
            target = n + 1;
            if (n == 300) hold_long = 1'b1;
            @(negedge i_clk);
            while (accepted_items < target) @(negedge i_clk);
            burst--;
        end
        i_valid = 1'b0;

        // Drain outstanding results
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rct_pkg.sv
rtl/rct_front.sv
rtl/rct_queue.sv
rtl/rct_back.sv
rtl/reference_count_table.sv
test/reference_count_table_tb.sv
